### hdl/block_average_2x2_pixelate_assert.svh
// Assertion macros for the 2x2 pixelate block.
`ifndef BLOCK_AVERAGE_2X2_PIXELATE_ASSERT_SVH
`define BLOCK_AVERAGE_2X2_PIXELATE_ASSERT_SVH

// checked only while out of reset
`define BAVG_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bavg assertion failed");

// checked at every edge, reset included
`define BAVG_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bavg assertion failed");

`endif

### hdl/bavg_pkg.sv
// Shared types, constants and helpers of the 2x2 pixelate block.
`timescale 1ns / 1ps
package bavg_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int SIZE_W   = 11;   // frame size registers and counters
  localparam int COORD_W  = 10;   // row / column on the result ports
  localparam int PIXEL_W  = 8;
  localparam int CFG_IDX_W = 1;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  // One queued request: a pass-through pixel or a full 2x2 block.
  typedef struct packed {
    logic                quad;
    logic                final_px;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic [PIXEL_W-1:0]  value;
  } q_entry_t;

  // zero reads as one, too large saturates
  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v, int maxv);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (int'(v) > maxv) begin
      res = SIZE_W'(maxv);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

### hdl/block_average_2x2_pixelate.sv
// Top level of the 2x2 block-average pixelate block.
// Each request passes the request queue and the back-end entry register before its results show on the output ports.
// Upper rows take one pixel per cycle while the queue is not full; on lower rows each 2x2 block
// expands into four results in the back end, so once the four-entry queue fills, full holds off input.
// Reset (synchronous, rst_n low): counters, queue and output clear, frame size
// returns to 1024 (saturated to the maximum); the line store is not cleared.
`timescale 1ns / 1ps
module block_average_2x2_pixelate import bavg_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  logic                 push,
  output logic                 full,
  input  logic [PIXEL_W-1:0]   in_pixel,
  output logic                 empty,
  input  logic                 pop,
  output logic [COORD_W-1:0]   out_row,
  output logic [COORD_W-1:0]   out_col,
  output logic [PIXEL_W-1:0]   out_value,
  output logic                 out_last_of_run,
  output logic                 out_frame_done
);

  logic     q_push, q_full, q_pop, q_empty;
  q_entry_t q_wdata, q_head;

  assign full = q_full;

  bavg_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (push),
    .in_pixel  (in_pixel),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_wdata)
  );

  bavg_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  bavg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_value       (out_value),
    .out_last_of_run (out_last_of_run),
    .out_frame_done  (out_frame_done)
  );

endmodule

### hdl/bavg_front.sv
// Front end: frame counters, line store of pair sums, classification of pixels.
`timescale 1ns / 1ps
module bavg_front import bavg_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  logic                 in_push,
  input  logic [PIXEL_W-1:0]   in_pixel,
  input  logic                 q_full,
  output logic                 q_push,
  output q_entry_t             q_entry
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LA_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  logic [SIZE_W-1:0]  width_r, width_nxt;
  logic [SIZE_W-1:0]  height_r, height_nxt;
  logic [SIZE_W-1:0]  col_r, col_nxt;
  logic [SIZE_W-1:0]  row_r, row_nxt;
  logic [PIXEL_W-1:0] upper_left_r;
  logic [PIXEL_W-1:0] held_lower_r;
  logic [8:0]         upper_sum_r;

  logic [8:0] line_mem [LINE_DEPTH];

  logic              accept;
  logic [SIZE_W:0]   col_inc, row_inc;
  logic              last_col, last_row, pass, is_final;
  logic [SIZE_W-2:0] pair_idx;
  logic [31:0]       pair_idx_ext;
  logic [LA_W-1:0]   pair_addr;
  logic              idx_ok;
  logic              upper_row, right_px;
  logic [9:0]        block_sum;

  assign accept    = in_push && !q_full;
  assign col_inc   = {1'b0, col_r} + (SIZE_W+1)'(1);
  assign row_inc   = {1'b0, row_r} + (SIZE_W+1)'(1);
  assign last_col  = (col_inc == {1'b0, width_r});
  assign last_row  = (row_inc == {1'b0, height_r});
  assign pass      = (width_r[0] && last_col) || (height_r[0] && last_row);
  assign is_final  = last_col && last_row;
  assign upper_row = !row_r[0];
  assign right_px  = col_r[0];

  assign pair_idx     = col_r[SIZE_W-1:1];
  assign pair_idx_ext = 32'(pair_idx);
  assign pair_addr    = pair_idx_ext[LA_W-1:0];
  assign idx_ok       = (int'(pair_idx) < LINE_DEPTH);

  assign block_sum = {1'b0, upper_sum_r} + 10'(held_lower_r) + 10'(in_pixel);

  always_comb begin
    q_push        = 1'b0;
    q_entry.quad     = 1'b0;
    q_entry.final_px = is_final;
    q_entry.row      = row_r[COORD_W-1:0];
    q_entry.col      = col_r[COORD_W-1:0];
    q_entry.value    = in_pixel;
    if (accept) begin
      if (pass) begin
        q_push = 1'b1;
      end else if (!upper_row && right_px) begin
        q_push        = 1'b1;
        q_entry.quad  = 1'b1;
        q_entry.value = block_sum[9:2];
      end
    end
  end

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  width_nxt  = clamp_size(cfg_data, MAX_WIDTH);
        REG_FRAME_HEIGHT: height_nxt = clamp_size(cfg_data, MAX_HEIGHT);
        default: ;
      endcase
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_inc >= {1'b0, width_r}) begin
        col_nxt = '0;
        row_nxt = (row_inc >= {1'b0, height_r}) ? '0 : row_inc[SIZE_W-1:0];
      end else begin
        col_nxt = col_inc[SIZE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= clamp_size(SIZE_RESET, MAX_WIDTH);
      height_r     <= clamp_size(SIZE_RESET, MAX_HEIGHT);
      col_r        <= '0;
      row_r        <= '0;
      held_lower_r <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      if (accept && !pass && !upper_row && !right_px) begin
        held_lower_r <= in_pixel;
      end
    end
  end

  // Upper row: keep the left pixel, write the pair sum with the right one.
  // Lower row: the left pixel fetches the pair sum for its right neighbor.
  always_ff @(posedge clk) begin
    if (accept && !pass) begin
      if (upper_row) begin
        if (!right_px) begin
          upper_left_r <= in_pixel;
        end else if (idx_ok) begin
          line_mem[pair_addr] <= 9'(upper_left_r) + 9'(in_pixel);
        end
      end else if (!right_px) begin
        upper_sum_r <= idx_ok ? line_mem[pair_addr] : 9'd0;
      end
    end
  end

endmodule

### hdl/bavg_queue.sv
// Short request queue between front end and back end.
`timescale 1ns / 1ps
module bavg_queue import bavg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_push,
  input  q_entry_t q_wdata,
  output logic     q_full,
  input  logic     q_pop,
  output logic     q_empty,
  output q_entry_t q_head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t          slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign q_full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_empty = (count_r == '0);
  assign q_head  = slot_r[rd_ptr_r];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= q_wdata;
    end
  end

endmodule

### hdl/bavg_back.sv
// Back end: expands queued requests into results, one result per cycle while pop is high and requests wait.
`timescale 1ns / 1ps
module bavg_back import bavg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  q_entry_t           q_head,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output logic [COORD_W-1:0] out_row,
  output logic [COORD_W-1:0] out_col,
  output logic [PIXEL_W-1:0] out_value,
  output logic               out_last_of_run,
  output logic               out_frame_done
);

  logic       cur_valid_r, cur_valid_nxt;
  q_entry_t   cur_r, cur_nxt;
  // phase walks 0..3 over a 2x2 block; a pass-through starts at 3
  logic [1:0] phase_r, phase_nxt;
  logic       entry_done, load;

  assign entry_done = (phase_r == 2'd3);
  assign load       = !cur_valid_r || (pop && entry_done);
  assign q_pop      = load && !q_empty;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    phase_nxt     = phase_r;
    if (load) begin
      cur_valid_nxt = !q_empty;
      cur_nxt       = q_head;
      phase_nxt     = q_head.quad ? 2'd0 : 2'd3;
    end else if (pop) begin
      phase_nxt = phase_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      phase_r     <= 2'd0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  assign empty           = !cur_valid_r;
  assign out_row         = phase_r[1] ? cur_r.row : cur_r.row - COORD_W'(1);
  assign out_col         = phase_r[0] ? cur_r.col : cur_r.col - COORD_W'(1);
  assign out_value       = cur_r.value;
  assign out_last_of_run = entry_done;
  assign out_frame_done  = entry_done && cur_r.final_px;

endmodule

### hdl/bavg_checker.sv
// Port-level checker of the 2x2 pixelate block, bound to the top level.
`timescale 1ns / 1ps
`include "block_average_2x2_pixelate_assert.svh"
module bavg_checker import bavg_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 empty,
  input logic                 pop,
  input logic [COORD_W-1:0]   out_row,
  input logic [COORD_W-1:0]   out_col,
  input logic [PIXEL_W-1:0]   out_value,
  input logic                 out_last_of_run,
  input logic                 out_frame_done
);

  // a waiting result holds until taken
  `BAVG_ASSERT(a_out_hold, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(out_row) && $stable(out_col) && $stable(out_value)))

  // the end of a frame is always the end of a run
  `BAVG_ASSERT(a_done_is_last, clk, rst_n, (!empty && out_frame_done) |-> out_last_of_run)

  // the rest of a 2x2 burst follows right behind its first results
  `BAVG_ASSERT(a_burst_continues, clk, rst_n, (!empty && pop && !out_last_of_run) |=> !empty)

  // reset leaves nothing on the output
  `BAVG_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> empty)

endmodule

bind block_average_2x2_pixelate bavg_checker u_bavg_checker (.*);

### test/block_average_2x2_pixelate_tb.sv
// Self-checking testbench of the 2x2 block-average pixelate block.
`timescale 1ns / 1ps
module block_average_2x2_pixelate_tb;
  import bavg_pkg::*;

  localparam int LINE_PAIRS    = DEF_MAX_WIDTH / 2;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_PIXELS = 220;
  localparam int EDGE_PIXELS   = 24;
  localparam int MAX_REPORTS   = 40;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIXEL_W-1:0] value;
    logic               last_of_run;
    logic               frame_done;
  } binned_px_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0]    cfg_data  = '0;
  logic                 push      = 1'b0;
  logic                 full;
  logic [PIXEL_W-1:0]   in_pixel  = '0;
  logic                 empty;
  logic                 pop       = 1'b0;
  logic [COORD_W-1:0]   out_row;
  logic [COORD_W-1:0]   out_col;
  logic [PIXEL_W-1:0]   out_value;
  logic                 out_last_of_run;
  logic                 out_frame_done;

  block_average_2x2_pixelate DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .push            (push),
    .full            (full),
    .in_pixel        (in_pixel),
    .empty           (empty),
    .pop             (pop),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_value       (out_value),
    .out_last_of_run (out_last_of_run),
    .out_frame_done  (out_frame_done)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // binning model state
  int unsigned        frm_width;
  int unsigned        frm_height;
  int unsigned        cur_row;
  int unsigned        cur_col;
  logic [8:0]         pair_sum [LINE_PAIRS];
  logic [PIXEL_W-1:0] held_px;
  binned_px_t         expected_bins [$];

  int err_count   = 0;
  int reports     = 0;
  int cycle_cnt   = 0;
  int pixels_sent = 0;
  bit tx_idle     = 1'b0;
  bit rx_idle     = 1'b0;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("block_average_2x2_pixelate verification failed");
      $finish;
    end
  end

  function automatic int unsigned legal_size(logic [SIZE_W-1:0] v, int unsigned maxv);
    if (v == '0) return 1;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic void queue_bin(int unsigned r, int unsigned c, logic [PIXEL_W-1:0] v,
                                    bit last, bit done);
    binned_px_t b;
    b.row         = COORD_W'(r);
    b.col         = COORD_W'(c);
    b.value       = v;
    b.last_of_run = last;
    b.frame_done  = done;
    expected_bins.push_back(b);
  endfunction

  function automatic void model_reset();
    frm_width  = legal_size(SIZE_RESET, DEF_MAX_WIDTH);
    frm_height = legal_size(SIZE_RESET, DEF_MAX_HEIGHT);
    cur_row    = 0;
    cur_col    = 0;
    held_px    = '0;
  endfunction

  // Advance the model by one accepted pixel and queue whatever it releases.
  function automatic void bin_pixel(logic [PIXEL_W-1:0] px);
    int unsigned        r;
    int unsigned        c;
    int unsigned        idx;
    bit                 final_px;
    logic [9:0]         total;
    logic [PIXEL_W-1:0] mean;
    r        = cur_row;
    c        = cur_col;
    idx      = c >> 1;
    final_px = (r + 1 == frm_height) && (c + 1 == frm_width);
    if ((frm_width[0] && c + 1 == frm_width) || (frm_height[0] && r + 1 == frm_height)) begin
      // odd edge pixel goes straight through
      queue_bin(r, c, px, 1'b1, final_px);
    end else if (r[0] == 1'b0) begin
      if (c[0] == 1'b0) pair_sum[idx] = {1'b0, px};
      else pair_sum[idx] = pair_sum[idx] + px;
    end else if (c[0] == 1'b0) begin
      held_px = px;
    end else begin
      total = pair_sum[idx] + held_px + px;
      mean  = total[9:2];
      queue_bin(r - 1, c - 1, mean, 1'b0, 1'b0);
      queue_bin(r - 1, c,     mean, 1'b0, 1'b0);
      queue_bin(r,     c - 1, mean, 1'b0, 1'b0);
      queue_bin(r,     c,     mean, 1'b1, final_px);
    end
    cur_col = c + 1;
    if (cur_col >= frm_width) begin
      cur_col = 0;
      cur_row = r + 1;
      if (cur_row >= frm_height) cur_row = 0;
    end
  endfunction

  function automatic logic [PIXEL_W-1:0] random_px();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return PIXEL_W'($urandom_range(0, 255));
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      err_count++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endfunction

  // Result side: sample at the falling edge, a request moves at the next rising edge.
  initial begin : result_checker
    int         stall;
    bit         took;
    binned_px_t want;
    stall = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(negedge clk);
      took = pop && !empty;
      if (took) begin
        if (expected_bins.size() == 0) begin
          err_count++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: unexpected result, expected none, actual row %0d col %0d value %0d",
                     $time, out_row, out_col, out_value);
          end
        end else begin
          want = expected_bins.pop_front();
          check_field("out_row", 16'(want.row), 16'(out_row));
          check_field("out_col", 16'(want.col), 16'(out_col));
          check_field("out_value", 16'(want.value), 16'(out_value));
          check_field("out_last_of_run", 16'(want.last_of_run), 16'(out_last_of_run));
          check_field("out_frame_done", 16'(want.frame_done), 16'(out_frame_done));
        end
      end
      @(posedge clk);
      if (took) stall = rx_idle ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // push stays high when the next request follows without a gap
  task automatic send_pixel(input logic [PIXEL_W-1:0] px);
    int gap;
    bit taken;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push     <= 1'b1;
    in_pixel <= px;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end
    bin_pixel(px);
    pixels_sent++;
  endtask

  task automatic send_random_pixels(input int n);
    for (int i = 0; i < n; i++) send_pixel(random_px());
  endtask

  // Hold off the input until every pending result has come out.
  task automatic wait_drained();
    push <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) frm_width = legal_size(value, DEF_MAX_WIDTH);
    else frm_height = legal_size(value, DEF_MAX_HEIGHT);
    cur_row = 0;
    cur_col = 0;
    @(posedge clk);
  endtask

  task automatic set_frame(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    if ($urandom_range(0, 1)) begin
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
    end else begin
      write_reg(REG_FRAME_HEIGHT, h);
      write_reg(REG_FRAME_WIDTH, w);
    end
  endtask

  // zero sizes read as one: every pixel is a whole frame
  task automatic test_one_pixel_frames();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    set_frame('0, '0);
    send_pixel('0);
    send_pixel('1);
    send_pixel(8'h5A);
  endtask

  task automatic test_full_blocks();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_frame(2, 2);
    repeat (4) send_pixel('1);
    send_pixel(8'd3);
    send_pixel('0);
    send_pixel('0);
    send_pixel('0);
  endtask

  task automatic test_odd_edges();
    tx_idle = 1'b1;
    rx_idle = 1'b0;
    set_frame(3, 3);
    send_random_pixels(9);
  endtask

  // a register write mid-frame starts a new frame; sender also pauses mid-frame
  task automatic test_frame_restart();
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    set_frame(4, 2);
    send_random_pixels(3);
    write_reg(REG_FRAME_WIDTH, 4);
    send_random_pixels(5);
    wait_drained();
    send_random_pixels(3);
  endtask

  // saturated registers: the start of a full-width row and of a full-height column
  task automatic test_size_extremes();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    set_frame('1, 1);
    send_random_pixels(EDGE_PIXELS);
    set_frame(1, '1);
    send_random_pixels(EDGE_PIXELS);
  endtask

  task automatic test_random_frames();
    int          start;
    int          n;
    int          kind;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    start = pixels_sent;
    while (pixels_sent < start + RANDOM_PIXELS) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      w = ($urandom_range(0, 15) == 0) ? '0 : SIZE_W'($urandom_range(1, 9));
      h = ($urandom_range(0, 15) == 0) ? '0 : SIZE_W'($urandom_range(1, 7));
      set_frame(w, h);
      n = legal_size(w, DEF_MAX_WIDTH) * legal_size(h, DEF_MAX_HEIGHT) * $urandom_range(1, 2);
      kind = $urandom_range(0, 7);
      if (kind == 0) n = $urandom_range(1, n);   // broken frame, cut by the next write
      for (int i = 0; i < n; i++) begin
        send_pixel(random_px());
        if (kind == 1 && i == n / 2) wait_drained();
      end
    end
  endtask

  initial begin
    model_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_one_pixel_frames();
    test_full_blocks();
    test_odd_edges();
    test_frame_restart();
    test_size_extremes();
    test_random_frames();
    wait_drained();
    if (err_count == 0) begin
      $display("block_average_2x2_pixelate verification clean");
    end else begin
      $display("block_average_2x2_pixelate verification failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/bavg_pkg.sv
hdl/bavg_front.sv
hdl/bavg_queue.sv
hdl/bavg_back.sv
hdl/block_average_2x2_pixelate.sv
hdl/bavg_checker.sv
test/block_average_2x2_pixelate_tb.sv
